@@ hw/rtl/frb_pkg.sv @@
`default_nettype none
package frb_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_BYTES = 64;

	localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LEN_W      = $clog2(SLOT_BYTES);
	localparam int ADDR_W     = $clog2(SLOT_COUNT * SLOT_BYTES);
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int FLEN_W     = 6;

	localparam logic [LEN_W-1:0]      MAX_LEN  = LEN_W'(SLOT_BYTES - 1);
	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

	// transaction kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PUSH_STORED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PUSH_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POP_BYTE     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PUSH_TRUNC   = 3'd4;

	typedef enum logic {
		CTRL_IDLE,
		CTRL_STREAM
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic push;       // accept a push byte
		logic pop_empty;  // pop on an empty queue
		logic pop_zero;   // pop of a zero-length frame
		logic pop_begin;  // latch oldest frame, start streaming
		logic pop_step;   // read one stored byte
	} frb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic zero_len;
		logic last_byte;
	} frb_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/frb_ctrl.sv @@
`default_nettype none
module frb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              kind,
	input  wire frb_pkg::frb_stat_t stat,
	output frb_pkg::frb_cmd_t      cmd,
	output logic                   busy
);

	frb_pkg::ctrl_state_t state_q, state_d;
	logic accept;

	assign accept = start && (state_q == frb_pkg::CTRL_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frb_pkg::CTRL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			frb_pkg::CTRL_IDLE: begin
				if (accept && kind == frb_pkg::KIND_POP && !stat.empty && !stat.zero_len)
					state_d = frb_pkg::CTRL_STREAM;
			end
			frb_pkg::CTRL_STREAM: begin
				if (stat.last_byte)
					state_d = frb_pkg::CTRL_IDLE;
			end
			default: state_d = frb_pkg::CTRL_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		case (state_q)
			frb_pkg::CTRL_IDLE: begin
				if (accept) begin
					if (kind == frb_pkg::KIND_PUSH) begin
						cmd.push = 1'b1;
					end else if (stat.empty) begin
						cmd.pop_empty = 1'b1;
					end else if (stat.zero_len) begin
						cmd.pop_zero = 1'b1;
					end else begin
						cmd.pop_begin = 1'b1;
					end
				end
			end
			frb_pkg::CTRL_STREAM: begin
				busy         = 1'b1;
				cmd.pop_step = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/frb_datapath.sv @@
`default_nettype none
module frb_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire frb_pkg::frb_cmd_t               cmd,
	input  wire logic [frb_pkg::BYTE_W-1:0]      data_byte,
	input  wire logic                            frame_end,
	output frb_pkg::frb_stat_t                   stat,
	output logic                                 strobe,
	output logic [frb_pkg::BYTE_W-1:0]           out_byte,
	output logic                                 out_last,
	output logic [frb_pkg::STATUS_W-1:0]         status,
	output logic [frb_pkg::FLEN_W-1:0]           frame_length
);

	localparam int IW = frb_pkg::SLOT_IDX_W;
	localparam int LW = frb_pkg::LEN_W;
	localparam int AW = frb_pkg::ADDR_W;

	// frame storage, contents undefined until written
	logic [frb_pkg::BYTE_W-1:0] mem [frb_pkg::SLOT_COUNT * frb_pkg::SLOT_BYTES];
	logic [frb_pkg::BYTE_W-1:0] rd_q;

	logic [LW-1:0] slot_len_q [frb_pkg::SLOT_COUNT];

	// pointers: slot index plus wrap bit
	logic [IW-1:0] widx_q, ridx_q;
	logic          wwrap_q, rwrap_q;
	logic          open_q, drop_q;
	logic [LW-1:0] wlen_q;       // bytes staged so far
	logic [LW-1:0] plen_q;       // length of frame being popped
	logic [LW-1:0] cnt_q;        // stream offset

	// result registers
	logic                          strobe_q, byte_sel_q, last_q;
	logic [frb_pkg::STATUS_W-1:0]  status_q;
	logic [LW-1:0]                 length_q;

	logic          full, opening, drop_now, room;
	logic [LW-1:0] cur_len, new_len, rd_len;
	logic          mem_we, free_slot;
	logic [AW-1:0] waddr, raddr;

	assign full    = (widx_q == ridx_q) && (wwrap_q != rwrap_q);
	assign opening = !open_q && !drop_q;
	assign drop_now = drop_q || (opening && full);
	assign cur_len = opening ? '0 : wlen_q;
	assign room    = cur_len < frb_pkg::MAX_LEN;
	assign new_len = room ? cur_len + LW'(1) : cur_len;
	assign mem_we  = cmd.push && !drop_now && room;
	assign rd_len  = slot_len_q[ridx_q];

	assign waddr = AW'(widx_q) * AW'(frb_pkg::SLOT_BYTES) + AW'(cur_len);
	assign raddr = AW'(ridx_q) * AW'(frb_pkg::SLOT_BYTES) + AW'(cnt_q);

	assign stat.empty     = (widx_q == ridx_q) && (wwrap_q == rwrap_q);
	assign stat.zero_len  = (rd_len == '0);
	assign stat.last_byte = (cnt_q == plen_q - LW'(1));

	assign free_slot = cmd.pop_zero || (cmd.pop_step && stat.last_byte);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= data_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_step)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q   <= '0;
			wwrap_q  <= 1'b0;
			ridx_q   <= '0;
			rwrap_q  <= 1'b0;
			open_q   <= 1'b0;
			drop_q   <= 1'b0;
			wlen_q   <= '0;
			plen_q   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < frb_pkg::SLOT_COUNT; i++)
				slot_len_q[i] <= '0;
		end else begin
			if (cmd.push) begin
				if (drop_now) begin
					drop_q <= !frame_end;
				end else begin
					wlen_q <= new_len;
					if (frame_end) begin
						open_q             <= 1'b0;
						slot_len_q[widx_q] <= new_len;
						if (widx_q == frb_pkg::LAST_IDX) begin
							widx_q  <= '0;
							wwrap_q <= !wwrap_q;
						end else begin
							widx_q <= widx_q + IW'(1);
						end
					end else begin
						open_q <= 1'b1;
					end
				end
			end
			if (cmd.pop_begin) begin
				plen_q <= rd_len;
				cnt_q  <= '0;
			end
			if (cmd.pop_step)
				cnt_q <= cnt_q + LW'(1);
			if (free_slot) begin
				slot_len_q[ridx_q] <= '0;
				if (ridx_q == frb_pkg::LAST_IDX) begin
					ridx_q  <= '0;
					rwrap_q <= !rwrap_q;
				end else begin
					ridx_q <= ridx_q + IW'(1);
				end
			end
			strobe_q <= cmd.push || cmd.pop_empty || cmd.pop_zero || cmd.pop_step;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			byte_sel_q <= 1'b0;
			last_q     <= 1'b1;
			if (drop_now) begin
				status_q <= frb_pkg::ST_PUSH_DROPPED;
				length_q <= '0;
			end else begin
				status_q <= room ? frb_pkg::ST_PUSH_STORED : frb_pkg::ST_PUSH_TRUNC;
				length_q <= new_len;
			end
		end else if (cmd.pop_empty) begin
			byte_sel_q <= 1'b0;
			last_q     <= 1'b1;
			status_q   <= frb_pkg::ST_POP_EMPTY;
			length_q   <= '0;
		end else if (cmd.pop_zero) begin
			byte_sel_q <= 1'b0;
			last_q     <= 1'b1;
			status_q   <= frb_pkg::ST_POP_BYTE;
			length_q   <= '0;
		end else if (cmd.pop_step) begin
			byte_sel_q <= 1'b1;
			last_q     <= stat.last_byte;
			status_q   <= frb_pkg::ST_POP_BYTE;
			length_q   <= plen_q;
		end
	end

	assign strobe       = strobe_q;
	assign out_byte     = (strobe_q && byte_sel_q) ? rd_q : '0;
	assign out_last     = last_q;
	assign status       = status_q;
	assign frame_length = frb_pkg::FLEN_W'(length_q);

endmodule
`default_nettype wire

@@ hw/rtl/frame_ring_buffer_core.sv @@
`default_nettype none
// Frame ring buffer: a queue of frames kept in fixed byte slots.
// Command channel: start/busy plus kind, data_byte, frame_end. A transaction
//   is taken on a rising edge with start high and busy low.
//   kind = push: one frame byte; frame_end commits the staged frame.
//   kind = pop: stream the oldest committed frame.
// Result channel: strobe marks one result for exactly one cycle; the
//   receiver cannot stall, so every strobed cycle is consumed.
// Result timing and throughput:
//   push       - one result the cycle after acceptance, one push per cycle.
//   pop empty / zero-length frame - one result the next cycle.
//   pop of N bytes - busy while the byte counter walks the
//     slot through the single read port of the byte memory; the frame
//     length is latched first, then bytes leave the registered read port
//     at one byte per cycle.
// Reset (arst_n low): pointers, slot lengths, staging flags and the strobe
//   clear at once; no clearing pass. Byte storage is left as is, since
//   only bytes already written are ever read back.
// A frame that begins while the queue is full is dropped whole (status 1);
// bytes past SLOT_BYTES-1 are discarded with status 4.
module frame_ring_buffer_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            kind,
	input  wire logic [frb_pkg::BYTE_W-1:0]      data_byte,
	input  wire logic                            frame_end,
	output logic                                 strobe,
	output logic [frb_pkg::BYTE_W-1:0]           out_byte,
	output logic                                 out_last,
	output logic [frb_pkg::STATUS_W-1:0]         status,
	output logic [frb_pkg::FLEN_W-1:0]           frame_length
);

	frb_pkg::frb_cmd_t  cmd;
	frb_pkg::frb_stat_t stat;

	// sequencer: decodes transactions, runs the pop stream
	frb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// pointers, slot lengths, byte memory, result registers
	frb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.frame_end    (frame_end),
		.stat         (stat),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.status       (status),
		.frame_length (frame_length)
	);

	// every streaming cycle yields a result the next cycle
	a_stream_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("stream cycle without result");

	// a push gives exactly one final result right after acceptance
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == frb_pkg::KIND_PUSH) |=> (strobe && out_last))
		else $error("push without result");

	// data bytes appear only on pop byte results
	a_byte_only_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_byte != '0) |-> (strobe && status == frb_pkg::ST_POP_BYTE))
		else $error("stray output byte");

	// empty pop reports no length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == frb_pkg::ST_POP_EMPTY) |-> (frame_length == '0 && out_last))
		else $error("bad empty pop result");

	// a dropped push byte never reports a length
	a_drop_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == frb_pkg::ST_PUSH_DROPPED) |-> (frame_length == '0))
		else $error("dropped byte with length");

endmodule
`default_nettype wire
